### hdl/i2a_pkg.sv
// ----------------------------------------------------------------------------
// i2a_pkg
// Shared types, operation codes and character helpers for the integer to
// ascii formatter.
// ----------------------------------------------------------------------------
`default_nettype none

package i2a_pkg;

  // default depth of the digit chain
  localparam int DEF_MAX_DIGITS = 20;

  // binary widths shifted into the chain
  localparam int WORD_BITS   = 32;
  localparam int PTR_BITS    = 64;
  localparam int SHIFT_CNT_W = $clog2(PTR_BITS + 1);

  // operation codes
  localparam logic [2:0] OP_SIGNED_DEC   = 3'd0;
  localparam logic [2:0] OP_UNSIGNED_DEC = 3'd1;
  localparam logic [2:0] OP_HEX_LOWER    = 3'd2;
  localparam logic [2:0] OP_HEX_UPPER    = 3'd3;
  localparam logic [2:0] OP_POINTER      = 3'd4;

  // ascii codes
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_X       = 8'h78;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;

  // input transaction
  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] value;
  } req_t;

  // output transaction
  typedef struct packed {
    logic [7:0]  character;
    logic        is_last;
    logic [31:0] char_count;
  } rsp_t;

  // control broadcast to every digit cell
  typedef struct packed {
    logic clear;
    logic bit_shift;
    logic digit_shift;
    logic decimal;
  } cell_ctrl_t;

  // digit value to ascii character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] wide;
    wide = {4'b0000, d};
    if (d < 4'd10) begin
      return CH_ZERO + wide;
    end else if (upper) begin
      return CH_UPPER_A + wide - 8'd10;
    end else begin
      return CH_LOWER_A + wide - 8'd10;
    end
  endfunction

endpackage

`default_nettype wire

### hdl/integer_to_ascii_formatter_unit.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit
// Formats one integer as signed/unsigned decimal, hex or pointer text and
// streams the characters most significant first.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. After acceptance the value is shifted
// one bit per cycle into a chain of digit cells (double dabble for decimal,
// plain shift for hex): 32 bits for 32-bit operations, 64 for pointer. A
// leading '-' or "0x" follows, then the chain shifts digits out of its top
// cell, dropping leading zeros at one per cycle and sending one character per
// cycle while the output is not stalled. The last character of each value
// carries is_last, and char_count is a running total that wraps at 2^32.
// Operation codes above four are accepted and produce no text.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_ascii_formatter_unit
  import i2a_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic req_valid,
  output      logic req_ready,
  input  wire req_t req,
  output      logic rsp_valid,
  input  wire logic rsp_ready,
  output      rsp_t rsp
);

  localparam int REMAIN_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CONV   = 6'b000010,
    S_SIGN   = 6'b000100,
    S_PFX0   = 6'b001000,
    S_PFX1   = 6'b010000,
    S_DIGITS = 6'b100000
  } state_t;

  state_t                 state, state_next;
  logic [SHIFT_CNT_W-1:0] shift_cnt, shift_cnt_next;
  logic [PTR_BITS-1:0]    shreg, shreg_next;
  logic [REMAIN_W-1:0]    remain, remain_next;
  logic                   started, started_next;
  logic                   negative, pointer, upper, decimal;
  logic [31:0]            emitted;

  cell_ctrl_t             ctrl;
  logic [3:0]             top_digit;
  logic                   chain_ovf;

  logic                   accept;
  logic                   op_ok;
  logic                   neg_in;
  logic [WORD_BITS-1:0]   mag_low;
  logic                   can_load;
  logic                   load;
  logic [7:0]             load_char;
  logic                   load_last;

  // input decode
  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign op_ok     = (req.operation <= OP_POINTER);
  assign neg_in    = (req.operation == OP_SIGNED_DEC) && req.value[WORD_BITS-1];
  assign mag_low   = neg_in ? (~req.value[WORD_BITS-1:0] + WORD_BITS'(1))
                            : req.value[WORD_BITS-1:0];
  assign can_load  = !rsp_valid || rsp_ready;

  // digit chain
  i2a_chain #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_chain (
    .clk       (clk),
    .ctrl      (ctrl),
    .bit_in    (shreg[PTR_BITS-1]),
    .top_digit (top_digit),
    .overflow  (chain_ovf)
  );

  // sequencer
  always_comb begin
    state_next     = state;
    shift_cnt_next = shift_cnt;
    shreg_next     = shreg;
    remain_next    = remain;
    started_next   = started;
    load           = 1'b0;
    load_char      = CH_ZERO;
    load_last      = 1'b0;
    ctrl           = '0;
    ctrl.decimal   = decimal;
    case (state)
      S_IDLE: begin
        if (accept && op_ok) begin
          ctrl.clear   = 1'b1;
          remain_next  = REMAIN_W'(MAX_DIGITS);
          started_next = 1'b0;
          if (req.operation == OP_POINTER) begin
            shreg_next     = req.value;
            shift_cnt_next = SHIFT_CNT_W'(PTR_BITS);
          end else begin
            shreg_next     = {mag_low, {(PTR_BITS-WORD_BITS){1'b0}}};
            shift_cnt_next = SHIFT_CNT_W'(WORD_BITS);
          end
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.bit_shift = 1'b1;
        shreg_next     = {shreg[PTR_BITS-2:0], 1'b0};
        shift_cnt_next = shift_cnt - SHIFT_CNT_W'(1);
        if (shift_cnt == SHIFT_CNT_W'(1)) begin
          if (negative) begin
            state_next = S_SIGN;
          end else if (pointer) begin
            state_next = S_PFX0;
          end else begin
            state_next = S_DIGITS;
          end
        end
      end
      S_SIGN: begin
        if (can_load) begin
          load       = 1'b1;
          load_char  = CH_MINUS;
          state_next = S_DIGITS;
        end
      end
      S_PFX0: begin
        if (can_load) begin
          load       = 1'b1;
          load_char  = CH_ZERO;
          state_next = S_PFX1;
        end
      end
      S_PFX1: begin
        if (can_load) begin
          load       = 1'b1;
          load_char  = CH_X;
          state_next = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (!started && (top_digit == 4'd0) && (remain != REMAIN_W'(1))) begin
          // drop a leading zero
          ctrl.digit_shift = 1'b1;
          remain_next      = remain - REMAIN_W'(1);
        end else if (can_load) begin
          load             = 1'b1;
          load_char        = digit_char(top_digit, upper);
          load_last        = (remain == REMAIN_W'(1));
          ctrl.digit_shift = 1'b1;
          remain_next      = remain - REMAIN_W'(1);
          started_next     = 1'b1;
          if (remain == REMAIN_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    shift_cnt <= shift_cnt_next;
    shreg     <= shreg_next;
    remain    <= remain_next;
    started   <= started_next;
    if (accept) begin
      negative <= neg_in;
      pointer  <= (req.operation == OP_POINTER);
      upper    <= (req.operation == OP_HEX_UPPER);
      decimal  <= (req.operation == OP_SIGNED_DEC) || (req.operation == OP_UNSIGNED_DEC);
    end
  end

  // output register and running count
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      emitted   <= 32'd0;
    end else begin
      if (load) begin
        rsp_valid <= 1'b1;
        emitted   <= emitted + 32'd1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp.character  <= load_char;
      rsp.is_last    <= load_last;
      rsp.char_count <= emitted + 32'd1;
    end
  end

  // no bit may leave the top of the chain during conversion
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (state == S_CONV) |-> !chain_ovf)
    else $error("digit chain overflow during conversion");

  // the final character of a value returns the sequencer to idle
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (load && load_last) |=> (state == S_IDLE))
    else $error("last character did not end the transaction");

  // the count steps by one for each character
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    load |=> (emitted == $past(emitted) + 32'd1))
    else $error("character count did not step by one");

  // digits remain while in the output phase
  a_remain_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIGITS) |-> (remain != '0))
    else $error("digit phase with no digits left");

  // a loaded character never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load |-> (!rsp_valid || rsp_ready))
    else $error("output register overwritten");

endmodule

`default_nettype wire

### hdl/i2a_cell.sv
// ----------------------------------------------------------------------------
// i2a_cell
// One digit of the conversion chain: a 4-bit digit with add-3 correction for
// decimal, bit shift toward the next digit, and whole-digit shift for output.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_cell
  import i2a_pkg::*;
(
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       carry_in,
  input  wire logic [3:0] digit_in,
  output      logic [3:0] digit,
  output      logic       carry_out
);

  logic [3:0] corrected;

  // add 3 when a decimal digit would reach ten after doubling
  always_comb begin
    if (ctrl.decimal && (digit >= 4'd5)) begin
      corrected = digit + 4'd3;
    end else begin
      corrected = digit;
    end
  end

  assign carry_out = corrected[3];

  // digit register
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= 4'd0;
    end else if (ctrl.bit_shift) begin
      digit <= {corrected[2:0], carry_in};
    end else if (ctrl.digit_shift) begin
      digit <= digit_in;
    end
  end

endmodule

`default_nettype wire

### hdl/i2a_chain.sv
// ----------------------------------------------------------------------------
// i2a_chain
// Row of digit cells, least significant at index 0. Bits enter at the bottom
// during conversion; digits move toward the top during output.
// ----------------------------------------------------------------------------
`default_nettype none

module i2a_chain
  import i2a_pkg::*;
#(
  parameter int MAX_DIGITS = DEF_MAX_DIGITS
) (
  input  wire logic       clk,
  input  wire cell_ctrl_t ctrl,
  input  wire logic       bit_in,
  output      logic [3:0] top_digit,
  output      logic       overflow
);

  logic [3:0] digits [MAX_DIGITS];
  logic       carry  [MAX_DIGITS];

  // cells linked by carry bits and digit paths
  for (genvar i = 0; i < MAX_DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      i2a_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (bit_in),
        .digit_in  (4'd0),
        .digit     (digits[i]),
        .carry_out (carry[i])
      );
    end else begin : g_rest
      i2a_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .carry_in  (carry[i-1]),
        .digit_in  (digits[i-1]),
        .digit     (digits[i]),
        .carry_out (carry[i])
      );
    end
  end

  assign top_digit = digits[MAX_DIGITS-1];
  assign overflow  = carry[MAX_DIGITS-1];

endmodule

`default_nettype wire
